// ===== rtl/program_stream_audio_demux_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef PROGRAM_STREAM_AUDIO_DEMUX_CORE_DEFINES_SVH
`define PROGRAM_STREAM_AUDIO_DEMUX_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PSAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define PSAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/psad_pkg.sv =====
`default_nettype none
package psad_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned StampW = 33;
    localparam int unsigned CodeW  = 3;
    localparam int unsigned SelW   = 9;
    localparam int unsigned OutW   = 56;
    localparam int unsigned FifoDepthDefault = 4;
    localparam logic [SelW-1:0] SelReset = 9'h1FF;

    localparam logic [CodeW-1:0] EV_AUDIO  = 3'd0;
    localparam logic [CodeW-1:0] EV_PACK   = 3'd1;
    localparam logic [CodeW-1:0] EV_SYS    = 3'd2;
    localparam logic [CodeW-1:0] EV_PAD    = 3'd3;
    localparam logic [CodeW-1:0] EV_APKT   = 3'd4;
    localparam logic [CodeW-1:0] EV_VIDEO  = 3'd5;
    localparam logic [CodeW-1:0] EV_USER   = 3'd6;

    localparam logic [0:0] REG_CHANNEL_SELECT = 1'b0;

    typedef enum logic [4:0] {
        PH_HUNT, PH_PACK, PH_PACK_STUFF, PH_LEN_HI, PH_LEN_LO, PH_SKIP,
        PH_VIDEO_MARK, PH_PES_STUFF, PH_STD_SKIP, PH_STD_C, PH_FLAGS, PH_HLEN,
        PH_PTS, PH_DTS, PH_EXT, PH_EXT_SKIP, PH_EXT2LEN, PH_IDEXT, PH_HDR_SKIP,
        PH_CHANNEL, PH_SUBSKIP, PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic              last_pkt;
        logic              first_pkt;
        logic [ByteW-1:0]  channel;
        logic [StampW-1:0] stamp;
        logic              valid_mark;
        logic [ByteW-1:0]  payload;
        logic [CodeW-1:0]  code;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/psad_parser.sv =====
`default_nettype none
// Front end: byte-serial parse state machine, one byte per cycle while i_step is high.
module psad_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [7:0]                 i_byte,
    input  wire logic [psad_pkg::SelW-1:0]  i_sel,
    input  wire logic                       i_cfg_we,
    input  wire logic [psad_pkg::SelW-1:0]  i_cfg_data,
    output      logic                       o_res_valid,
    output      psad_pkg::t_result          o_res
);
    psad_pkg::t_phase r_ph, n_ph;
    logic [31:0] r_cs, n_cs;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_hdr, n_hdr, r_flg, n_flg;
    logic [4:0]  r_xsk, n_xsk;
    logic [32:0] r_acc, n_acc, r_pst, n_pst;
    logic        r_p1, n_p1, r_lat, n_lat;
    logic [7:0]  r_psub, n_psub, r_lsub, n_lsub;
    logic [2:0]  r_stf, n_stf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= psad_pkg::PH_HUNT; r_cs <= 32'hFF; r_rem <= '0; r_hdr <= '0;
            r_flg <= '0; r_xsk <= '0; r_acc <= '0; r_pst <= '0; r_p1 <= 1'b0;
            r_psub <= '0; r_lsub <= '0; r_lat <= 1'b0; r_stf <= '0;
        end else begin
            r_ph <= n_ph; r_cs <= n_cs; r_rem <= n_rem; r_hdr <= n_hdr;
            r_flg <= n_flg; r_xsk <= n_xsk; r_acc <= n_acc; r_pst <= n_pst;
            r_p1 <= n_p1; r_psub <= n_psub; r_lsub <= n_lsub; r_lat <= n_lat;
            r_stf <= n_stf;
        end
    end

    always_comb begin
        logic [7:0]  b, kind;
        logic [32:0] acc_t;
        logic        ok, sel_nn, disp, allow_std, do_post, do_hdrskip, do_after;
        logic        do_extafter, do_payload, pay_acc;
        logic [7:0]  f;
        logic [4:0]  sk;
        b = i_byte; kind = r_cs[7:0]; sel_nn = ~i_sel[8];
        ok = 1'b1; disp = 1'b0; allow_std = 1'b0; do_post = 1'b0;
        do_hdrskip = 1'b0; do_after = 1'b0; do_extafter = 1'b0;
        do_payload = 1'b0; pay_acc = 1'b1; f = '0; sk = '0;
        acc_t = '0;
        n_ph = r_ph; n_cs = r_cs; n_rem = r_rem; n_hdr = r_hdr; n_flg = r_flg;
        n_xsk = r_xsk; n_acc = r_acc; n_pst = r_pst; n_p1 = r_p1;
        n_psub = r_psub; n_lsub = r_lsub; n_lat = r_lat; n_stf = r_stf;
        o_res_valid = 1'b0; o_res = '0;
        if (i_cfg_we && !i_cfg_data[8]) begin
            n_lsub = i_cfg_data[7:0]; n_lat = 1'b1;
        end
        if (i_step) begin
            unique case (r_ph)
                psad_pkg::PH_HUNT: begin
                    n_cs = {r_cs[23:0], b};
                    if (n_cs[31:8] == 24'h000001) begin
                        if (n_cs[7:0] == 8'hBA) begin
                            n_hdr = '0; n_ph = psad_pkg::PH_PACK;
                        end else if (n_cs[7:0] == 8'hBB || n_cs[7:0] == 8'hBD ||
                                     n_cs[7:0] == 8'hBE || n_cs[7:0] == 8'hBF ||
                                     n_cs[7:4] == 4'hE) begin
                            n_ph = psad_pkg::PH_LEN_HI;
                        end else begin
                            n_cs = 32'hFF;
                            if (b == 8'hB2) begin
                                o_res_valid = 1'b1; o_res.code = psad_pkg::EV_USER;
                                o_res.valid_mark = 1'b1;
                            end
                        end
                    end
                end
                psad_pkg::PH_PACK: begin
                    priority case (r_hdr)
                        8'd0: ok = (b & 8'hC4) == 8'h44;
                        8'd2, 8'd4: ok = b[2];
                        8'd5: ok = b[0];
                        8'd8: ok = b[1:0] == 2'b11;
                        default: ok = 1'b1;
                    endcase
                    if (!ok) begin
                        n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF; o_res_valid = 1'b1;
                        o_res.code = psad_pkg::EV_PACK;
                    end else if (r_hdr >= 8'd9) begin
                        n_stf = b[2:0];
                        if (b[2:0] == 3'd0) begin
                            n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF; o_res_valid = 1'b1;
                            o_res.code = psad_pkg::EV_PACK; o_res.valid_mark = 1'b1;
                        end else n_ph = psad_pkg::PH_PACK_STUFF;
                    end else n_hdr = r_hdr + 8'd1;
                end
                psad_pkg::PH_PACK_STUFF: begin
                    n_stf = r_stf - 3'd1;
                    if (b != 8'hFF || n_stf == 3'd0) begin
                        n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF; o_res_valid = 1'b1;
                        o_res.code = psad_pkg::EV_PACK; o_res.valid_mark = (b == 8'hFF);
                    end
                end
                psad_pkg::PH_LEN_HI: begin
                    n_rem = {b, 8'h00}; n_ph = psad_pkg::PH_LEN_LO;
                end
                psad_pkg::PH_LEN_LO: begin
                    n_rem = {r_rem[15:8], b};
                    if (kind == 8'hBB || kind == 8'hBE || kind == 8'hBF) begin
                        if (n_rem == '0) begin
                            n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF;
                        end else n_ph = psad_pkg::PH_SKIP;
                        o_res_valid = 1'b1; o_res.valid_mark = 1'b1;
                        o_res.code = (kind == 8'hBB) ? psad_pkg::EV_SYS : psad_pkg::EV_PAD;
                    end else if (kind == 8'hBD) begin
                        n_p1 = 1'b1; n_pst = '0; n_flg = '0; n_hdr = '0;
                        if (n_rem == '0) do_post = 1'b1;
                        else n_ph = psad_pkg::PH_PES_STUFF;
                        o_res_valid = 1'b1; o_res.valid_mark = 1'b1;
                        o_res.code = psad_pkg::EV_APKT;
                    end else n_ph = psad_pkg::PH_VIDEO_MARK;
                end
                psad_pkg::PH_VIDEO_MARK: begin
                    o_res_valid = 1'b1; o_res.code = psad_pkg::EV_VIDEO;
                    o_res.valid_mark = b[7:6] == 2'b10;
                    if (r_rem == '0) begin
                        n_ph = psad_pkg::PH_HUNT; n_cs = {24'h0000FF, b};
                    end else begin
                        n_rem = r_rem - 16'd1;
                        if (n_rem == '0) begin
                            n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF;
                        end else n_ph = psad_pkg::PH_SKIP;
                    end
                end
                psad_pkg::PH_SKIP: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (n_rem == '0) begin
                        n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF;
                    end
                end
                psad_pkg::PH_PES_STUFF: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (b == 8'hFF) begin
                        if (n_rem == '0) do_post = 1'b1;
                    end else begin
                        disp = 1'b1; allow_std = 1'b1;
                    end
                end
                psad_pkg::PH_STD_SKIP: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    n_ph = psad_pkg::PH_STD_C;
                end
                psad_pkg::PH_STD_C: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    disp = 1'b1;
                end
                psad_pkg::PH_FLAGS: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    n_flg = b; n_ph = psad_pkg::PH_HLEN;
                end
                psad_pkg::PH_HLEN: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    n_hdr = b;
                    if (r_flg[7]) begin
                        n_acc = '0; n_stf = '0; n_ph = psad_pkg::PH_PTS;
                    end else do_after = 1'b1;
                end
                psad_pkg::PH_PTS, psad_pkg::PH_DTS: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (r_hdr != '0) n_hdr = r_hdr - 8'd1;
                    unique case (r_stf)
                        3'd0: acc_t = {30'd0, b[3:1]};
                        3'd1, 3'd3: acc_t = {r_acc[24:0], b};
                        default: acc_t = {r_acc[25:0], b[7:1]};
                    endcase
                    n_acc = acc_t;
                    n_stf = r_stf + 3'd1;
                    if (n_stf >= 3'd5) begin
                        if (r_ph == psad_pkg::PH_PTS) begin
                            n_pst = acc_t;
                            if (r_flg[6]) begin
                                n_stf = '0; n_ph = psad_pkg::PH_DTS;
                            end else do_after = 1'b1;
                        end else do_after = 1'b1;
                    end
                end
                psad_pkg::PH_EXT: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (r_hdr != '0) n_hdr = r_hdr - 8'd1;
                    sk = {1'b0, b[7:4] & 4'hB};
                    sk = sk + (sk & 5'h09);
                    f = b;
                    if (b[6] || {3'd0, sk} > n_hdr) begin
                        f = '0; sk = '0;
                    end
                    n_flg = {7'd0, f[0]}; n_xsk = sk;
                    if (sk != '0) n_ph = psad_pkg::PH_EXT_SKIP;
                    else do_extafter = 1'b1;
                end
                psad_pkg::PH_EXT_SKIP: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (r_hdr != '0) n_hdr = r_hdr - 8'd1;
                    if (r_xsk != '0) n_xsk = r_xsk - 5'd1;
                    if (n_xsk == '0) do_extafter = 1'b1;
                end
                psad_pkg::PH_EXT2LEN: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (r_hdr != '0) n_hdr = r_hdr - 8'd1;
                    if (b[6:0] != '0) n_ph = psad_pkg::PH_IDEXT;
                    else do_hdrskip = 1'b1;
                end
                psad_pkg::PH_IDEXT: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (r_hdr != '0) n_hdr = r_hdr - 8'd1;
                    if (!b[7]) n_p1 = 1'b0;
                    do_hdrskip = 1'b1;
                end
                psad_pkg::PH_HDR_SKIP: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    if (r_hdr != '0) n_hdr = r_hdr - 8'd1;
                    if (n_hdr == '0) do_post = 1'b1;
                end
                psad_pkg::PH_CHANNEL: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    n_psub = b;
                    if (sel_nn) ok = b == i_sel[7:0];
                    else if (r_lat) ok = b == r_lsub;
                    else begin
                        ok = 1'b1; n_lsub = b; n_lat = 1'b1;
                    end
                    n_flg = {7'd0, ok};
                    n_stf = (b[7:4] == 4'hB) ? 3'd4 : 3'd3;
                    n_ph = psad_pkg::PH_SUBSKIP;
                end
                psad_pkg::PH_SUBSKIP: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    n_stf = r_stf - 3'd1;
                    if (n_stf == '0) begin
                        do_payload = 1'b1; pay_acc = r_flg[0];
                    end
                end
                psad_pkg::PH_PAYLOAD: begin
                    if (r_rem != '0) n_rem = r_rem - 16'd1;
                    n_flg = {7'd0, r_flg[0]};
                    if (n_rem == '0) begin
                        n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF;
                    end
                    if (r_flg[0]) begin
                        o_res_valid = 1'b1; o_res.code = psad_pkg::EV_AUDIO;
                        o_res.payload = b; o_res.stamp = r_pst; o_res.channel = r_psub;
                        o_res.first_pkt = r_flg[1]; o_res.last_pkt = (n_rem == '0);
                    end
                end
                default: begin
                    n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF;
                end
            endcase
            // Shared PES header dispatch (after stuffing or STD buffer).
            if (disp) begin
                if (allow_std && b[7:6] == 2'b01) n_ph = psad_pkg::PH_STD_SKIP;
                else if (b[7:5] == 3'b001) begin
                    n_flg = {1'b1, b[4], 6'd0}; n_hdr = '0;
                    n_acc = {30'd0, b[3:1]}; n_stf = 3'd1; n_ph = psad_pkg::PH_PTS;
                end else if (b[7:6] == 2'b10) n_ph = psad_pkg::PH_FLAGS;
                else do_post = 1'b1;
            end
            if (do_after) begin
                f = (r_ph == psad_pkg::PH_HLEN) ? r_flg : r_flg;
                if (f[5:0] != '0 && n_hdr == '0) f = f & 8'hC0;
                n_flg = f;
                if (f[0]) n_ph = psad_pkg::PH_EXT;
                else do_hdrskip = 1'b1;
            end
            if (do_extafter) begin
                if (n_flg[0]) n_ph = psad_pkg::PH_EXT2LEN;
                else do_hdrskip = 1'b1;
            end
            if (do_hdrskip) begin
                if (n_hdr == '0) do_post = 1'b1;
                else n_ph = psad_pkg::PH_HDR_SKIP;
            end
            if (do_post) begin
                if (n_p1) n_ph = psad_pkg::PH_CHANNEL;
                else begin
                    if (sel_nn) n_psub = i_sel[7:0];
                    else if (n_lat) n_psub = n_lsub;
                    else n_psub = '0;
                    do_payload = 1'b1; pay_acc = 1'b1;
                end
            end
            if (do_payload) begin
                n_flg = pay_acc ? 8'd3 : 8'd2;
                if (n_rem == '0) begin
                    n_ph = psad_pkg::PH_HUNT; n_cs = 32'hFF;
                end else n_ph = psad_pkg::PH_PAYLOAD;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/psad_fifo.sv =====
`default_nettype none
// Result queue between parser and output port.
module psad_fifo #(
    parameter int unsigned Depth = psad_pkg::FifoDepthDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire psad_pkg::t_result  i_data,
    output      logic               o_full,
    output      logic               o_valid,
    input  wire logic               i_pop,
    output      psad_pkg::t_result  o_data
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    psad_pkg::t_result r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= f_inc(r_wp);
            if (i_pop)  r_rp <= f_inc(r_rp);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    assign o_full  = (r_cnt == (AW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

// ===== rtl/program_stream_audio_demux_core.sv =====
`default_nettype none
// Program stream audio demultiplexer.
// Input: s_axis_* carries one program stream byte per item (tdata[7:0]).
// Output: m_axis_* carries one result item: event code, audio payload byte,
//   validity mark, 33-bit PTS, channel, first/last markers (see tdata port).
// Config: APB register 0 at address 0 is channel_select (9-bit signed);
//   -1 latches the first private-stream-1 substream seen. Write only when idle.
// Throughput: one byte per clock unless the queue is full; the parser is
//   a single state machine handling each byte in the cycle it is accepted.
// Queueing: a result is written to the queue at the accept edge, and m_axis
//   presents the head of the queue.
// Stall: results go into a small queue; s_axis_tready drops only while the
//   queue is full, so the parser keeps working while the sink stalls briefly.
// Reset: synchronous active-low; parser returns to start-code hunting,
//   queue empties, channel_select returns to -1.
module program_stream_audio_demux_core #(
    parameter int unsigned FifoDepth = psad_pkg::FifoDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] event_code, [10:3] payload_byte, [11] looks_valid,
    // [44:12] presentation_stamp, [52:45] audio_channel,
    // [53] first_of_packet, [54] last_of_packet, [55] zero
    output      logic [55:0] m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    logic [psad_pkg::SelW-1:0] r_sel;
    logic cfg_we, step, res_valid, full;
    psad_pkg::t_result res, q_data;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'b00)
                    && (paddr[1] == psad_pkg::REG_CHANNEL_SELECT);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sel <= psad_pkg::SelReset;
        else if (cfg_we) r_sel <= pwdata[8:0];
    end
    // Sign-extended register readback.
    assign prdata = (paddr == 2'b00) ? {{23{r_sel[8]}}, r_sel} : 32'd0;

    assign s_axis_tready = !full;
    assign step = s_axis_tvalid && s_axis_tready;

    psad_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(s_axis_tdata),
        .i_sel(r_sel), .i_cfg_we(cfg_we), .i_cfg_data(pwdata[8:0]),
        .o_res_valid(res_valid), .o_res(res)
    );

    psad_fifo #(.Depth(FifoDepth)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_valid), .i_data(res),
        .o_full(full), .o_valid(m_axis_tvalid),
        .i_pop(m_axis_tvalid && m_axis_tready), .o_data(q_data)
    );
    assign m_axis_tdata = {1'b0, q_data};
endmodule
`default_nettype wire

// ===== rtl/psad_checker.sv =====
`default_nettype none
`include "program_stream_audio_demux_core_defines.svh"
// Port-level checks for the demultiplexer.
module psad_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        pready
);
    `PSAD_ASSERT_IMP(a_audio_no_mark, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] == psad_pkg::EV_AUDIO, !m_axis_tdata[11])
    `PSAD_ASSERT_IMP(a_event_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7 && !m_axis_tdata[55])
    `PSAD_ASSERT_IMP(a_nonaudio_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] != psad_pkg::EV_AUDIO, m_axis_tdata[54:3] == {43'd0, 1'b1, 8'd0} || m_axis_tdata[54:3] == 52'd0)
    `PSAD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PSAD_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind program_stream_audio_demux_core psad_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);
`default_nettype wire
